### rtl/i2c_eeprom_byte_access_master_top_macros.svh
// Assertion macros used by the serial EEPROM master sequencer
`ifndef I2C_EEPROM_BYTE_ACCESS_MASTER_TOP_MACROS_SVH
`define I2C_EEPROM_BYTE_ACCESS_MASTER_TOP_MACROS_SVH

// Same-cycle implication, checked on every clock edge outside reset
`define EEB_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset
`define EEB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/eeb_pkg.sv
// Shared types and codes for the serial EEPROM byte-access master
`timescale 1ns / 1ps

package eeb_pkg;

  // Request codes
  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_DEVICE_SELECT   = 2'd0;
  localparam logic [1:0] CFG_ACK_WAIT_LIMIT  = 2'd1;
  localparam logic [1:0] CFG_POST_WRITE_WAIT = 2'd2;

  // Reset values of the configuration registers
  localparam logic [6:0]  DEVICE_SELECT_RST   = 7'd80;
  localparam logic [7:0]  ACK_WAIT_LIMIT_RST  = 8'd250;
  localparam logic [15:0] POST_WRITE_WAIT_RST = 16'd110;

  // Bus sequencer phases, one-hot
  typedef enum logic [21:0] {
    P_IDLE      = 22'h000001,
    P_START1    = 22'h000002,
    P_START2    = 22'h000004,
    P_START3    = 22'h000008,
    P_BIT_LOW   = 22'h000010,
    P_BIT_DATA  = 22'h000020,
    P_BIT_HIGH  = 22'h000040,
    P_END_LOW   = 22'h000080,
    P_RELEASE   = 22'h000100,
    P_ACK_HIGH  = 22'h000200,
    P_ACK_POLL  = 22'h000400,
    P_ACK_LOW   = 22'h000800,
    P_RD_LOW    = 22'h001000,
    P_RD_REL    = 22'h002000,
    P_RD_HIGH   = 22'h004000,
    P_RD_SAMPLE = 22'h008000,
    P_NACK_HIGH = 22'h010000,
    P_NACK_LOW  = 22'h020000,
    P_STOP1     = 22'h040000,
    P_STOP2     = 22'h080000,
    P_STOP3     = 22'h100000,
    P_WAIT      = 22'h200000
  } phase_t;

  // Which byte of the sequence is on the bus
  typedef enum logic [1:0] {
    BS_SELECT  = 2'd0,
    BS_ADDRESS = 2'd1,
    BS_DATA    = 2'd2
  } byte_stage_t;

  // One result per tick
  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       ack_missing;
  } res_t;

endpackage

### rtl/eeb_core.sv
// Bus sequencer: one half-bit line action per accepted tick
`timescale 1ns / 1ps
`include "i2c_eeprom_byte_access_master_top_macros.svh"

module eeb_core
  import eeb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  logic [1:0]  req_type,
  input  logic [7:0]  mem_address,
  input  logic [7:0]  write_data,
  input  logic        sda_in,
  input  logic [6:0]  device_select,
  input  logic [7:0]  ack_wait_limit,
  input  logic [15:0] post_write_wait,
  output res_t        result
);

  phase_t      phase, phase_next;
  byte_stage_t byte_stage, byte_stage_next;
  logic        access_is_read, access_is_read_next;
  logic [7:0]  address_hold, address_hold_next;
  logic [7:0]  data_hold, data_hold_next;
  logic [7:0]  shift_bits, shift_bits_next;
  logic [3:0]  bit_count, bit_count_next;
  logic [7:0]  ack_wait_count, ack_wait_count_next;
  logic [15:0] write_wait_count, write_wait_count_next;
  logic        ack_fail_flag, ack_fail_flag_next;
  logic        scl_drive, scl_drive_next;
  logic        sda_drive, sda_drive_next;

  logic [3:0]  bit_count_inc;
  logic [15:0] wait_dec;
  logic        done;
  logic [7:0]  rd_byte;
  logic        miss;

  assign bit_count_inc = bit_count + 4'd1;
  assign wait_dec = (write_wait_count != 16'd0) ? write_wait_count - 16'd1 : write_wait_count;

  // Work out this tick's line action and the next sequencer state
  always_comb begin
    phase_next            = phase;
    byte_stage_next       = byte_stage;
    access_is_read_next   = access_is_read;
    address_hold_next     = address_hold;
    data_hold_next        = data_hold;
    shift_bits_next       = shift_bits;
    bit_count_next        = bit_count;
    ack_wait_count_next   = ack_wait_count;
    write_wait_count_next = write_wait_count;
    ack_fail_flag_next    = ack_fail_flag;
    scl_drive_next        = scl_drive;
    sda_drive_next        = sda_drive;
    done                  = 1'b0;
    rd_byte               = 8'd0;
    miss                  = 1'b0;

    unique case (phase)
      P_IDLE: begin
        if (req_type == REQ_WRITE || req_type == REQ_READ) begin
          access_is_read_next = (req_type == REQ_READ);
          address_hold_next   = mem_address;
          data_hold_next      = write_data;
          ack_fail_flag_next  = 1'b0;
          byte_stage_next     = BS_SELECT;
          sda_drive_next      = 1'b1;
          phase_next          = P_START2;
        end
      end
      P_START1: begin
        sda_drive_next = 1'b1;
        phase_next     = P_START2;
      end
      P_START2: begin
        scl_drive_next = 1'b1;
        phase_next     = P_START3;
      end
      P_START3: begin
        // Start condition, then load the select byte with its rw bit
        sda_drive_next  = 1'b0;
        shift_bits_next = {device_select, (byte_stage == BS_DATA)};
        bit_count_next  = 4'd0;
        phase_next      = P_BIT_LOW;
      end
      P_BIT_LOW: begin
        scl_drive_next = 1'b0;
        phase_next     = P_BIT_DATA;
      end
      P_BIT_DATA: begin
        sda_drive_next  = shift_bits[7];
        shift_bits_next = {shift_bits[6:0], 1'b0};
        phase_next      = P_BIT_HIGH;
      end
      P_BIT_HIGH: begin
        scl_drive_next = 1'b1;
        bit_count_next = bit_count_inc;
        phase_next     = (bit_count_inc >= 4'd8) ? P_END_LOW : P_BIT_LOW;
      end
      P_END_LOW: begin
        scl_drive_next = 1'b0;
        phase_next     = P_RELEASE;
      end
      P_RELEASE: begin
        sda_drive_next      = 1'b1;
        ack_wait_count_next = 8'd0;
        phase_next          = P_ACK_HIGH;
      end
      P_ACK_HIGH: begin
        scl_drive_next = 1'b1;
        phase_next     = P_ACK_POLL;
      end
      P_ACK_POLL: begin
        // Poll for the acknowledge; flag it and move on at the limit
        if (!sda_in) begin
          phase_next = P_ACK_LOW;
        end else if (ack_wait_count >= ack_wait_limit) begin
          ack_fail_flag_next = 1'b1;
          phase_next         = P_ACK_LOW;
        end else begin
          ack_wait_count_next = ack_wait_count + 8'd1;
        end
      end
      P_ACK_LOW: begin
        scl_drive_next = 1'b0;
        case (byte_stage)
          BS_SELECT: begin
            byte_stage_next = BS_ADDRESS;
            shift_bits_next = address_hold;
            bit_count_next  = 4'd0;
            phase_next      = P_BIT_LOW;
          end
          BS_ADDRESS: begin
            byte_stage_next = BS_DATA;
            if (access_is_read) begin
              phase_next = P_START1;
            end else begin
              shift_bits_next = data_hold;
              bit_count_next  = 4'd0;
              phase_next      = P_BIT_LOW;
            end
          end
          default: begin
            phase_next = access_is_read ? P_RD_LOW : P_STOP1;
          end
        endcase
      end
      P_RD_LOW: begin
        scl_drive_next  = 1'b0;
        bit_count_next  = 4'd0;
        shift_bits_next = 8'd0;
        phase_next      = P_RD_REL;
      end
      P_RD_REL: begin
        sda_drive_next = 1'b1;
        phase_next     = P_RD_HIGH;
      end
      P_RD_HIGH: begin
        scl_drive_next = 1'b1;
        phase_next     = P_RD_SAMPLE;
      end
      P_RD_SAMPLE: begin
        shift_bits_next = {shift_bits[6:0], sda_in};
        scl_drive_next  = 1'b0;
        bit_count_next  = bit_count_inc;
        phase_next      = (bit_count_inc >= 4'd8) ? P_NACK_HIGH : P_RD_HIGH;
      end
      P_NACK_HIGH: begin
        sda_drive_next = 1'b1;
        scl_drive_next = 1'b1;
        phase_next     = P_NACK_LOW;
      end
      P_NACK_LOW: begin
        scl_drive_next = 1'b0;
        phase_next     = P_STOP1;
      end
      P_STOP1: begin
        sda_drive_next = 1'b0;
        phase_next     = P_STOP2;
      end
      P_STOP2: begin
        scl_drive_next = 1'b1;
        phase_next     = P_STOP3;
      end
      P_STOP3: begin
        // Stop condition completes the sequence
        sda_drive_next = 1'b1;
        done           = 1'b1;
        miss           = ack_fail_flag;
        if (access_is_read) begin
          data_hold_next = shift_bits;
          rd_byte        = shift_bits;
          phase_next     = P_IDLE;
        end else begin
          write_wait_count_next = post_write_wait;
          phase_next = (post_write_wait != 16'd0) ? P_WAIT : P_IDLE;
        end
      end
      P_WAIT: begin
        write_wait_count_next = wait_dec;
        if (wait_dec == 16'd0) begin
          phase_next = P_IDLE;
        end
      end
      default: begin
        phase_next = P_IDLE;
      end
    endcase
  end

  // Advance the sequencer on each accepted tick
  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= P_IDLE;
      byte_stage       <= BS_SELECT;
      access_is_read   <= 1'b0;
      address_hold     <= 8'd0;
      data_hold        <= 8'd0;
      shift_bits       <= 8'd0;
      bit_count        <= 4'd0;
      ack_wait_count   <= 8'd0;
      write_wait_count <= 16'd0;
      ack_fail_flag    <= 1'b0;
      scl_drive        <= 1'b1;
      sda_drive        <= 1'b1;
    end else if (accept) begin
      phase            <= phase_next;
      byte_stage       <= byte_stage_next;
      access_is_read   <= access_is_read_next;
      address_hold     <= address_hold_next;
      data_hold        <= data_hold_next;
      shift_bits       <= shift_bits_next;
      bit_count        <= bit_count_next;
      ack_wait_count   <= ack_wait_count_next;
      write_wait_count <= write_wait_count_next;
      ack_fail_flag    <= ack_fail_flag_next;
      scl_drive        <= scl_drive_next;
      sda_drive        <= sda_drive_next;
    end
  end

  // Drive the result of this tick from the post-action state
  always_comb begin
    result.scl_level   = scl_drive_next;
    result.sda_level   = sda_drive_next;
    result.busy_res    = (phase_next != P_IDLE);
    result.done_res    = done;
    result.read_data   = rd_byte;
    result.ack_missing = miss;
  end

  `EEB_ASSERT_NEXT(a_phase_hold, !accept, $stable(phase), "phase moved without a tick")
  `EEB_ASSERT_SAME(a_miss_done, result.ack_missing, result.done_res, "ack flag off a done tick")
  `EEB_ASSERT_NEXT(a_wait_end, accept && phase == P_WAIT && write_wait_count == 16'd1,
                   phase == P_IDLE, "write wait did not end")

endmodule

### rtl/eeb_outreg.sv
// Result register that holds a request until the receiver takes it
`timescale 1ns / 1ps

module eeb_outreg
  import eeb_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic load_valid,
  output logic load_stall,
  input  res_t load_res,
  output logic out_valid,
  input  logic out_stall,
  output res_t out_res
);

  // Take a new result whenever the slot is empty or drains this cycle
  assign load_stall = out_valid && out_stall;

  // Track occupancy of the slot
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_valid && !load_stall) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Capture the payload on load
  always_ff @(posedge clk) begin
    if (load_valid && !load_stall) begin
      out_res <= load_res;
    end
  end

endmodule

### rtl/i2c_eeprom_byte_access_master_top.sv
// Serial EEPROM byte-access master: configuration registers, sequencer and result register
//
// Each accepted input request is one bit-timing tick: the sequencer performs one SCL/SDA
// action and one result request comes out, registered, from the output register.
// A new tick is taken every clock cycle as long as the output register is empty or being
// drained; the rate is set by the single next-state step of the sequencer. A byte write
// or random read starts only on a tick that arrives while the block is idle, and a missing
// acknowledge is reported with done but does not abort the sequence. Write configuration
// registers only while the block is idle.
`timescale 1ns / 1ps

module i2c_eeprom_byte_access_master_top
  import eeb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // Configuration write port
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  // Tick requests
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  req_type,
  input  logic [7:0]  mem_address,
  input  logic [7:0]  write_data,
  input  logic        sda_in,
  // Results
  output logic        out_valid,
  input  logic        out_stall,
  output logic        scl_level,
  output logic        sda_level,
  output logic        busy_res,
  output logic        done_res,
  output logic [7:0]  read_data,
  output logic        ack_missing
);

  logic [6:0]  device_select;
  logic [7:0]  ack_wait_limit;
  logic [15:0] post_write_wait;
  logic        accept;
  res_t        core_res;
  res_t        out_res;

  // Write configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      device_select   <= DEVICE_SELECT_RST;
      ack_wait_limit  <= ACK_WAIT_LIMIT_RST;
      post_write_wait <= POST_WRITE_WAIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DEVICE_SELECT:   device_select   <= cfg_data[6:0];
        CFG_ACK_WAIT_LIMIT:  ack_wait_limit  <= cfg_data[7:0];
        CFG_POST_WRITE_WAIT: post_write_wait <= cfg_data;
        default: ;
      endcase
    end
  end

  assign accept = in_valid && !in_stall;

  eeb_core u_core (
    .clk             (clk),
    .rst             (rst),
    .accept          (accept),
    .req_type        (req_type),
    .mem_address     (mem_address),
    .write_data      (write_data),
    .sda_in          (sda_in),
    .device_select   (device_select),
    .ack_wait_limit  (ack_wait_limit),
    .post_write_wait (post_write_wait),
    .result          (core_res)
  );

  eeb_outreg u_outreg (
    .clk        (clk),
    .rst        (rst),
    .load_valid (in_valid),
    .load_stall (in_stall),
    .load_res   (core_res),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_res    (out_res)
  );

  // Split the result onto its ports
  assign scl_level   = out_res.scl_level;
  assign sda_level   = out_res.sda_level;
  assign busy_res    = out_res.busy_res;
  assign done_res    = out_res.done_res;
  assign read_data   = out_res.read_data;
  assign ack_missing = out_res.ack_missing;

endmodule
